/* rtl/tcw_pkg.sv */
// shared types and constants for the text console writer
package tcw_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_PUT    = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [11:0] position;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
    logic        position_error;
  } rsp_t;

  localparam int unsigned CELL_W       = 16;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_BLANK_FILL,
    ST_RESULT
  } state_t;

endpackage

/* rtl/text_console_writer.sv */
// top level of the text console writer: sequencer, cell store, result register
//
//   channel | direction | payload | transaction when
//   cmd     | in        | cmd_t   | cmd_valid && !cmd_stall
//   rsp     | out       | rsp_t   | rsp_valid && !rsp_stall
//
// one command at a time: accept, execute, hand result to the output register
// append and put go through execute and result; read adds a wait state for the registered memory read
// clear sweeps every cell, one cell blanked per cycle
// an append that scrolls adds a copy sweep, then a bottom row blank
// after reset a clearing pass over every cell holds cmd_stall high
// a new command is taken while a finished result still waits in the output register
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  logic              res_valid;
  logic              res_ready;
  rsp_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // output register is free when empty or being drained this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  tcw_seq #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_cell_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register: control cleared by reset, payload loaded on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  // a command is never taken while the sequencer still offers a result
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |-> !res_valid)
    else $error("command accepted while a result is pending");

  // a result that cannot move holds until the output register frees
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("pending result dropped");

  // scroll only comes from append, position errors only from put and read
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.scrolled && rsp.position_error))
    else $error("scrolled and position_error both set");

endmodule

/* rtl/tcw_cell_mem.sv */
// character cell store: one write port, one registered read port
module tcw_cell_mem
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tcw_seq.sv */
// command sequencer: cursor, cell writes, scroll copy and blank sweeps
module tcw_seq
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS    = 25,
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ADDR_W  = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output rsp_t              res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_IDX = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

  state_t            state, state_next;
  cmd_t              item, item_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic [ADDR_W-1:0] copy_dst, copy_dst_next;
  logic              copy_pend, copy_pend_next;
  logic              read_done, read_done_next;
  logic              scrolled, scrolled_next;
  logic              perr, perr_next;
  logic [7:0]        rd_char, rd_char_next;
  logic [7:0]        rd_attr, rd_attr_next;

  logic              wrap;
  logic              pos_ok;
  logic [ADDR_W-1:0] pos_idx;
  logic [ADDR_W-1:0] cur_idx;

  assign pos_ok  = 32'(item.position) < CELL_COUNT;
  assign pos_idx = ADDR_W'(item.position);
  assign cur_idx = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);

  assign res.cursor_position = 11'(cur_idx);
  assign res.cell_char       = rd_char;
  assign res.cell_attr       = rd_attr;
  assign res.scrolled        = scrolled;
  assign res.position_error  = perr;

  always_comb begin
    state_next     = state;
    item_next      = item;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    sweep_next     = sweep;
    copy_dst_next  = copy_dst;
    copy_pend_next = copy_pend;
    read_done_next = read_done;
    scrolled_next  = scrolled;
    perr_next      = perr;
    rd_char_next   = rd_char;
    rd_attr_next   = rd_attr;
    wrap           = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sweep;
    mem_wdata      = BLANK_CELL;
    mem_re         = 1'b0;
    mem_raddr      = sweep;
    cmd_stall      = 1'b1;
    res_valid      = 1'b0;

    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        if (sweep == LAST_IDX) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          item_next     = cmd;
          scrolled_next = 1'b0;
          perr_next     = 1'b0;
          rd_char_next  = '0;
          rd_attr_next  = '0;
          state_next    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_RESULT;
        case (item.mode)
          MODE_APPEND: begin
            if (item.char_code == NEWLINE_CODE) begin
              wrap = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cur_idx;
              mem_wdata = {item.attribute, item.char_code};
              if (cur_col == LAST_COL) begin
                wrap = 1'b1;
              end else begin
                cur_col_next = cur_col + COL_W'(1);
              end
            end
            if (wrap) begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                // scroll: copy rows up, then blank the bottom row
                scrolled_next  = 1'b1;
                sweep_next     = COLS_A;
                copy_pend_next = 1'b0;
                read_done_next = 1'b0;
                state_next     = ST_SCROLL_COPY;
              end else begin
                cur_row_next = cur_row + ROW_W'(1);
              end
            end
          end
          MODE_PUT: begin
            if (pos_ok) begin
              mem_we    = 1'b1;
              mem_waddr = pos_idx;
              mem_wdata = {item.attribute, item.char_code};
            end else begin
              perr_next = 1'b1;
            end
          end
          MODE_CLEAR: begin
            sweep_next = '0;
            state_next = ST_BLANK_FILL;
          end
          MODE_READ: begin
            if (pos_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = pos_idx;
              state_next = ST_READ_WAIT;
            end else begin
              perr_next = 1'b1;
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_READ_WAIT: begin
        rd_char_next = mem_rdata[7:0];
        rd_attr_next = mem_rdata[15:8];
        state_next   = ST_RESULT;
      end

      ST_SCROLL_COPY: begin
        // read one cell ahead, write it one row up on the next cycle
        if (copy_pend) begin
          mem_we    = 1'b1;
          mem_waddr = copy_dst;
          mem_wdata = mem_rdata;
        end
        if (!read_done) begin
          mem_re         = 1'b1;
          mem_raddr      = sweep;
          copy_dst_next  = sweep - COLS_A;
          copy_pend_next = 1'b1;
          if (sweep == LAST_IDX) begin
            read_done_next = 1'b1;
          end else begin
            sweep_next = sweep + ADDR_W'(1);
          end
        end else begin
          copy_pend_next = 1'b0;
          sweep_next     = BOTTOM_IDX;
          state_next     = ST_BLANK_FILL;
        end
      end

      ST_BLANK_FILL: begin
        mem_we = 1'b1;
        if (sweep == LAST_IDX) begin
          state_next = ST_RESULT;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end

      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      copy_pend <= 1'b0;
      read_done <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      copy_pend <= copy_pend_next;
      read_done <= read_done_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    copy_dst <= copy_dst_next;
    scrolled <= scrolled_next;
    perr     <= perr_next;
    rd_char  <= rd_char_next;
    rd_attr  <= rd_attr_next;
  end

endmodule
